// ===== src/ptw_pkg.sv =====
// Shared types and constants for the page-table walker.
`timescale 1ns / 1ps
package ptw_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int INDEX_W           = 9;
    localparam int OFFSET_W          = 12;
    localparam int FRAME_W           = 40;
    localparam int FRAME_LSB         = 12;
    localparam int LVL_W             = 3;
    localparam int BIT_PRESENT       = 0;
    localparam int BIT_DEMAND        = 9;

    localparam logic [63:0] ENTRY_CLEAR_MASK = 64'h0000_0000_0000_0201;
    localparam logic [11:0] ENTRY_NEW_FLAGS  = 12'h003;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_XLATE = 3'd2;
    localparam logic [2:0] OP_FREE  = 3'd3;
    localparam logic [2:0] OP_FAULT = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
    localparam logic [2:0] ST_MISALIGNED = 3'd2;
    localparam logic [2:0] ST_MAPPED     = 3'd3;
    localparam logic [2:0] ST_UNHANDLED  = 3'd4;
    localparam logic [2:0] ST_NO_FRAME   = 3'd5;
    localparam logic [2:0] ST_OUTSIDE    = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] word_index;
        logic [63:0] word_data;
        logic [47:0] virt_addr;
        logic [39:0] new_frame;
    } ptw_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  stop_level;
        logic [51:0] phys_addr;
        logic [63:0] read_data;
    } ptw_out_t;

    typedef enum logic [1:0] {
        WK_MAPPED,
        WK_MISSING,
        WK_OUTSIDE
    } ptw_walk_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_WALK_ISSUE,
        S_WALK_CHECK,
        S_UPDATE,
        S_DONE
    } ptw_state_t;

    typedef struct packed {
        logic load_item;
        logic clear_wr;
        logic raw_wr;
        logic raw_rd;
        logic capture_word;
        logic walk_start;
        logic walk_rd;
        logic walk_outside;
        logic walk_step;
        logic update_wr;
        logic finish;
    } ptw_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic [2:0] opcode;
        logic       word_ok;
        logic       misaligned;
        logic       frame_outside;
        logic       entry_present;
        logic       last_level;
        logic       update_needed;
    } ptw_stat_t;

endpackage

// ===== src/ptw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== src/ptw_ctrl.sv =====
// Controller state machine for the page-table walker.
`timescale 1ns / 1ps
module ptw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ptw_pkg::ptw_stat_t stat,
    output ptw_pkg::ptw_cmd_t  cmd
);
    import ptw_pkg::*;

    ptw_state_t state_reg;
    ptw_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                case (stat.opcode)
                    OP_READ:  state_next = stat.word_ok ? S_RD_WAIT : S_DONE;
                    OP_XLATE: state_next = S_WALK_ISSUE;
                    OP_FAULT: state_next = S_WALK_ISSUE;
                    OP_FREE:  state_next = stat.misaligned ? S_DONE : S_WALK_ISSUE;
                    default:  state_next = S_DONE;
                endcase
            end
            S_RD_WAIT: state_next = S_DONE;
            S_WALK_ISSUE: begin
                state_next = stat.frame_outside ? S_DONE : S_WALK_CHECK;
            end
            S_WALK_CHECK: begin
                if (!stat.entry_present || stat.last_level) state_next = S_UPDATE;
                else state_next = S_WALK_ISSUE;
            end
            S_UPDATE: state_next = S_DONE;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_CLEAR: cmd.clear_wr = 1'b1;
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            S_EXEC: begin
                case (stat.opcode)
                    OP_WRITE: cmd.raw_wr = stat.word_ok;
                    OP_READ:  cmd.raw_rd = stat.word_ok;
                    OP_XLATE: cmd.walk_start = 1'b1;
                    OP_FAULT: cmd.walk_start = 1'b1;
                    OP_FREE:  cmd.walk_start = !stat.misaligned;
                    default:  cmd.walk_start = 1'b0;
                endcase
            end
            S_RD_WAIT: cmd.capture_word = 1'b1;
            S_WALK_ISSUE: begin
                cmd.walk_outside = stat.frame_outside;
                cmd.walk_rd      = !stat.frame_outside;
            end
            S_WALK_CHECK: cmd.walk_step = 1'b1;
            S_UPDATE: cmd.update_wr = stat.update_needed;
            S_DONE: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    assign m_valid = m_valid_reg;
endmodule

// ===== src/ptw_dpath.sv =====
// Datapath for the page-table walker: item, walk registers, table store, result.
`timescale 1ns / 1ps
module ptw_dpath #(
    parameter int LEVELS       = 4,
    parameter int STORE_FRAMES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptw_pkg::ptw_cmd_t  cmd,
    output ptw_pkg::ptw_stat_t stat,
    input  ptw_pkg::ptw_in_t   s_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_data,
    output ptw_pkg::ptw_out_t  m_data
);
    import ptw_pkg::*;

    localparam int STORE_WORDS = STORE_FRAMES * ENTRIES_PER_TABLE;
    localparam int SAW         = $clog2(STORE_WORDS);

    logic [2:0]           root_frame_reg;
    logic [SAW-1:0]       clr_cnt_reg;
    ptw_in_t              item_reg;
    logic [LVL_W-1:0]     level_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [SAW-1:0]       slot_reg;
    logic [63:0]          entry_reg;
    ptw_walk_t            kind_reg;
    ptw_out_t             m_data_reg;

    logic [63:0]          va_ext;
    logic [63:0]          va_shift;
    logic [5:0]           sh_amt;
    logic [INDEX_W-1:0]   tbl_idx;
    logic [SAW-1:0]       slot_now;
    logic [SAW-1:0]       word_addr;
    logic [63:0]          update_data;
    logic [63:0]          rd_data;
    logic                 ram_we;
    logic [SAW-1:0]       ram_waddr;
    logic [63:0]          ram_wdata;
    logic                 ram_re;
    logic [SAW-1:0]       ram_raddr;
    logic [2:0]           walk_status;
    ptw_out_t             res;

    assign va_ext    = {16'b0, item_reg.virt_addr};
    assign sh_amt    = 6'(OFFSET_W + INDEX_W * (LEVELS - 1 - int'(level_reg)));
    assign va_shift  = va_ext >> sh_amt;
    assign tbl_idx   = va_shift[INDEX_W-1:0];
    assign slot_now  = SAW'({frame_reg, tbl_idx});
    assign word_addr = SAW'(item_reg.word_index);

    assign stat.clear_done    = clr_cnt_reg == SAW'(STORE_WORDS - 1);
    assign stat.opcode        = item_reg.opcode;
    assign stat.word_ok       = 32'(item_reg.word_index) < 32'(STORE_WORDS);
    assign stat.misaligned    = |item_reg.virt_addr[OFFSET_W-1:0];
    assign stat.frame_outside = frame_reg >= FRAME_W'(STORE_FRAMES);
    assign stat.entry_present = rd_data[BIT_PRESENT];
    assign stat.last_level    = level_reg == LVL_W'(LEVELS - 1);
    assign stat.update_needed =
        (item_reg.opcode == OP_FREE && kind_reg == WK_MAPPED) ||
        (item_reg.opcode == OP_FAULT && kind_reg == WK_MISSING &&
         level_reg == LVL_W'(LEVELS - 1) && entry_reg[BIT_DEMAND] &&
         item_reg.new_frame != '0);

    assign update_data = (item_reg.opcode == OP_FREE) ? (entry_reg & ~ENTRY_CLEAR_MASK)
                                                      : {12'b0, item_reg.new_frame,
                                                         ENTRY_NEW_FLAGS};

    always_comb begin
        ram_we    = cmd.clear_wr || cmd.raw_wr || cmd.update_wr;
        ram_waddr = slot_reg;
        ram_wdata = update_data;
        if (cmd.clear_wr) begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.raw_wr) begin
            ram_waddr = word_addr;
            ram_wdata = item_reg.word_data;
        end
        ram_re    = cmd.raw_rd || cmd.walk_rd;
        ram_raddr = cmd.raw_rd ? word_addr : slot_now;
    end

    ptw_ram #(
        .WIDTH (64),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_frame_reg <= '0;
            clr_cnt_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) root_frame_reg <= cfg_data;
            if (cmd.clear_wr) clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
        if (cmd.capture_word) entry_reg <= rd_data;
        if (cmd.walk_start) begin
            level_reg <= '0;
            frame_reg <= FRAME_W'(root_frame_reg);
        end
        if (cmd.walk_outside) kind_reg <= WK_OUTSIDE;
        if (cmd.walk_rd) slot_reg <= slot_now;
        if (cmd.walk_step) begin
            entry_reg <= rd_data;
            if (!rd_data[BIT_PRESENT]) begin
                kind_reg <= WK_MISSING;
            end else begin
                frame_reg <= rd_data[FRAME_LSB +: FRAME_W];
                level_reg <= level_reg + 1'b1;
                if (stat.last_level) kind_reg <= WK_MAPPED;
            end
        end
        if (cmd.finish) m_data_reg <= res;
    end

    assign walk_status = (kind_reg == WK_OUTSIDE) ? ST_OUTSIDE : ST_NOT_MAPPED;

    always_comb begin
        res = '0;
        case (item_reg.opcode)
            OP_WRITE: begin
                res.status = stat.word_ok ? ST_OK : ST_OUTSIDE;
            end
            OP_READ: begin
                res.status    = stat.word_ok ? ST_OK : ST_OUTSIDE;
                res.read_data = stat.word_ok ? entry_reg : '0;
            end
            OP_XLATE: begin
                res.stop_level = level_reg;
                if (kind_reg == WK_MAPPED) begin
                    res.phys_addr = {frame_reg, item_reg.virt_addr[OFFSET_W-1:0]};
                end else begin
                    res.status = walk_status;
                end
            end
            OP_FREE: begin
                if (stat.misaligned) begin
                    res.status = ST_MISALIGNED;
                end else begin
                    res.stop_level = level_reg;
                    if (kind_reg == WK_MAPPED) begin
                        res.phys_addr = {frame_reg, OFFSET_W'(0)};
                    end else begin
                        res.status = walk_status;
                    end
                end
            end
            OP_FAULT: begin
                res.stop_level = level_reg;
                if (kind_reg == WK_MAPPED) begin
                    res.status = ST_MAPPED;
                end else if (kind_reg == WK_OUTSIDE) begin
                    res.status = ST_OUTSIDE;
                end else if (level_reg != LVL_W'(LEVELS - 1) || !entry_reg[BIT_DEMAND]) begin
                    res.status = ST_UNHANDLED;
                end else if (item_reg.new_frame == '0) begin
                    res.status = ST_NO_FRAME;
                end else begin
                    res.phys_addr = {item_reg.new_frame, OFFSET_W'(0)};
                end
            end
            default: res.status = ST_UNHANDLED;
        endcase
    end

    assign m_data = m_data_reg;
endmodule

// ===== src/four_level_page_table_walker_core.sv =====
// Top level of the page-table walker: controller, datapath and table store.
//
//  channel   ports                      beat
//  input     s_valid s_ready s_data     one operation (ptw_in_t)
//  result    m_valid m_ready m_data     one result (ptw_out_t)
//  config    cfg_valid cfg_ready cfg_data  root_frame, always ready
//
// Write and read use the table store directly; translate, free and fault walk
// it one level at a time, reading each entry through the registered read port
// of the single table store. After reset the store is zeroed, all
// STORE_FRAMES*512 words (4096 by default), with s_ready low.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module four_level_page_table_walker_core #(
    parameter int LEVELS       = 4,
    parameter int STORE_FRAMES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptw_pkg::ptw_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ptw_pkg::ptw_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data
);
    import ptw_pkg::*;

    ptw_cmd_t  cmd;
    ptw_stat_t stat;

    assign cfg_ready = 1'b1;

    ptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptw_dpath #(
        .LEVELS       (LEVELS),
        .STORE_FRAMES (STORE_FRAMES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );
endmodule
